/* design/gocd_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the gyro offset calibration block
package gocd_pkg;

  localparam int unsigned RATE_W = 16;

  typedef enum logic {
    FUNC_SAMPLE  = 1'b0,
    FUNC_RESTART = 1'b1
  } func_e;

  typedef struct packed {
    logic clear;
    logic cal;
    logic last;
  } axis_ctl_t;

endpackage

/* design/gyro_offset_calibrate_deadband_core.sv */
`timescale 1ns / 1ps
// gyro zero-rate offset calibration with dead band, top level
// the result of an accepted sample is on the output register in the next cycle
// throughput: one transaction per cycle, limited only by the output register stall
// the first 2^CAL_LOG2 samples after reset or a restart produce no result
// reset clears sums, peaks, biases, the sample count and the output valid
module gyro_offset_calibrate_deadband_core import gocd_pkg::*; #(
  parameter int unsigned CAL_LOG2 = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic signed [RATE_W-1:0] rate_x_i,
  input  logic signed [RATE_W-1:0] rate_y_i,
  input  logic signed [RATE_W-1:0] rate_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [RATE_W-1:0] adj_x_o,
  output logic signed [RATE_W-1:0] adj_y_o,
  output logic signed [RATE_W-1:0] adj_z_o
);

  localparam int unsigned CntW = CAL_LOG2 + 1;
  localparam logic [CntW-1:0] CntLast = CntW'((1 << CAL_LOG2) - 1);

  logic            accept, restart, produce;
  logic [CntW-1:0] cal_count_q, cal_count_d;
  logic            cal_done_q, cal_done_d;
  logic            out_valid_q, out_valid_d;
  axis_ctl_t       ctl;
  logic signed [RATE_W-1:0] adj_x, adj_y, adj_z;
  logic signed [RATE_W-1:0] adj_x_q, adj_y_q, adj_z_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign restart    = (func_i == FUNC_RESTART);
  assign produce    = accept && !restart && cal_done_q;

  assign ctl.clear = accept && restart;
  assign ctl.cal   = accept && !restart && !cal_done_q;
  assign ctl.last  = ctl.cal && (cal_count_q == CntLast);

  always_comb begin
    cal_count_d = cal_count_q;
    cal_done_d  = cal_done_q;
    if (ctl.clear) begin
      cal_count_d = '0;
      cal_done_d  = 1'b0;
    end else if (ctl.cal) begin
      cal_count_d = cal_count_q + CntW'(1);
      if (ctl.last) begin
        cal_done_d = 1'b1;
      end
    end
  end

  assign out_valid_d = produce || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_count_q <= '0;
      cal_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cal_count_q <= cal_count_d;
      cal_done_q  <= cal_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      adj_x_q <= adj_x;
      adj_y_q <= adj_y;
      adj_z_q <= adj_z;
    end
  end

  gocd_axis #(.CAL_LOG2(CAL_LOG2)) u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rate_i (rate_x_i),
    .adj_o  (adj_x)
  );

  gocd_axis #(.CAL_LOG2(CAL_LOG2)) u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rate_i (rate_y_i),
    .adj_o  (adj_y)
  );

  gocd_axis #(.CAL_LOG2(CAL_LOG2)) u_axis_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rate_i (rate_z_i),
    .adj_o  (adj_z)
  );

  assign out_valid_o = out_valid_q;
  assign adj_x_o     = adj_x_q;
  assign adj_y_o     = adj_y_q;
  assign adj_z_o     = adj_z_q;

endmodule

/* design/gocd_axis.sv */
`timescale 1ns / 1ps
// one axis: calibration sum, peak and bias, offset correction with dead band
module gocd_axis import gocd_pkg::*; #(
  parameter int unsigned CAL_LOG2 = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  axis_ctl_t                ctl_i,
  input  logic signed [RATE_W-1:0] rate_i,
  output logic signed [RATE_W-1:0] adj_o
);

  localparam int unsigned AccW = RATE_W + CAL_LOG2;

  logic signed [AccW-1:0]   acc_q, acc_d, acc_sum;
  logic signed [RATE_W-1:0] peak_q, peak_d;
  logic signed [RATE_W-1:0] bias_q, bias_d;
  logic        [RATE_W-1:0] diff;
  logic        [RATE_W:0]   mag;
  logic                     dead;

  assign acc_sum = acc_q + AccW'(rate_i);

  always_comb begin
    acc_d  = acc_q;
    peak_d = peak_q;
    bias_d = bias_q;
    if (ctl_i.clear) begin
      acc_d  = '0;
      peak_d = '0;
    end else if (ctl_i.cal) begin
      acc_d = acc_sum;
      if (rate_i > peak_q) begin
        peak_d = rate_i;
      end
      if (ctl_i.last) begin
        bias_d = acc_sum[AccW-1:CAL_LOG2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      peak_q <= '0;
      bias_q <= '0;
    end else begin
      acc_q  <= acc_d;
      peak_q <= peak_d;
      bias_q <= bias_d;
    end
  end

  // corrected value and its magnitude against the peak
  assign diff = rate_i - bias_q;
  assign mag  = diff[RATE_W-1] ? ((RATE_W+1)'(0) - {1'b1, diff}) : {1'b0, diff};
  assign dead = mag < {1'b0, peak_q};
  assign adj_o = dead ? '0 : diff;

endmodule

/* design/gocd_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the gyro offset calibration block, bound to the top level
module gocd_checker import gocd_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     func_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [RATE_W-1:0] adj_x_o,
  input logic signed [RATE_W-1:0] adj_y_o,
  input logic signed [RATE_W-1:0] adj_z_o
);

  // stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  // stalled result payload holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(adj_x_o) && $stable(adj_y_o) && $stable(adj_z_o))
    else $error("stalled result changed");

  // input only stalls while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // restart transaction yields no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_RESTART) |=> !out_valid_o)
    else $error("result after restart");

endmodule

bind gyro_offset_calibrate_deadband_core gocd_checker u_gocd_checker (.*);
